@@ hw/rtl/fen_rv_pkg.sv @@
// -----------------------------------------------------------------------------
// fen_rv_pkg
// Shared types and constants of the FEN record validator.
// -----------------------------------------------------------------------------
package fen_rv_pkg;

  // Record shape
  localparam int unsigned FenTokens   = 6;
  localparam int unsigned RankSquares = 8;
  localparam int unsigned LastRank    = 7;

  // Verdict codes, first failing check wins
  localparam logic [3:0] ErrNone      = 4'd0;
  localparam logic [3:0] ErrCount     = 4'd1;
  localparam logic [3:0] ErrBoard     = 4'd2;
  localparam logic [3:0] ErrSide      = 4'd3;
  localparam logic [3:0] ErrCastling  = 4'd4;
  localparam logic [3:0] ErrEnPassant = 4'd5;
  localparam logic [3:0] ErrHalfmove  = 4'd6;
  localparam logic [3:0] ErrFullmove  = 4'd7;
  localparam logic [3:0] ErrRankSum   = 4'd8;

  // Token positions (token index minus one)
  localparam logic [2:0] TokBoard     = 3'd0;
  localparam logic [2:0] TokSide      = 3'd1;
  localparam logic [2:0] TokCastling  = 3'd2;
  localparam logic [2:0] TokEnPassant = 3'd3;
  localparam logic [2:0] TokHalfmove  = 3'd4;
  localparam logic [2:0] TokFullmove  = 3'd5;

  // Class of the first byte of a token
  localparam logic [1:0] FirstOther  = 2'd0;
  localparam logic [1:0] FirstDash   = 2'd1;
  localparam logic [1:0] FirstLetter = 2'd2;

  // Character classes of one byte
  typedef struct packed {
    logic       space;
    logic       digit;
    logic       nz_digit;
    logic       board_sym;
    logic       slash;
    logic       side_sym;
    logic       castle;
    logic       dash;
    logic       file;
    logic       ep_rank;
    logic [3:0] squares;
  } char_class_t;

  // One verdict
  typedef struct packed {
    logic       is_valid;
    logic [3:0] error_code;
  } verdict_t;

endpackage

@@ hw/rtl/fen_rv_if.sv @@
// -----------------------------------------------------------------------------
// fen_rv_if
// Valid/ready channels of the FEN record validator: byte in, verdict out.
// -----------------------------------------------------------------------------
interface fen_rv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_final;

  modport source (output valid, output char_byte, output is_final, input ready);
  modport sink   (input valid, input char_byte, input is_final, output ready);
endinterface

interface fen_rv_verdict_if;
  logic       valid;
  logic       ready;
  logic       is_valid;
  logic [3:0] error_code;

  modport source (output valid, output is_valid, output error_code, input ready);
  modport sink   (input valid, input is_valid, input error_code, output ready);
endinterface

@@ hw/rtl/fen_record_validator_core.sv @@
// -----------------------------------------------------------------------------
// fen_record_validator_core
// Streaming FEN record checker: one byte per word, one verdict per record.
// -----------------------------------------------------------------------------
// Usage:
//   char_i carries one byte of the record per word; is_final marks the last
//   byte, which belongs to the record. verdict_o carries one word per record:
//   is_valid and error_code (first failing check in the order count, board,
//   side, castling, en passant, halfmove, fullmove, rank sum).
//   A byte is held in an input register, then folded into the running token
//   state; on the final byte the verdict is written to the output register.
//   The verdict is registered in the output register once the final byte
//   has stepped out of the input register. Throughput is one byte per cycle,
//   set by the state update, unless char_i.ready is low. Bytes keep flowing
//   while a verdict waits in the output register; only a second final byte
//   stalls behind an untaken verdict, and then char_i.ready drops until verdict_o is taken.
//   Reset clears the token state and both valid flags; the next byte starts
//   a new record. After each verdict the state also returns to reset.
// -----------------------------------------------------------------------------
module fen_record_validator_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  fen_rv_char_if.sink             char_i,
  fen_rv_verdict_if.source        verdict_o
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_final_q;
  logic                 out_valid_q, out_valid_d;
  fen_rv_pkg::verdict_t out_q;
  fen_rv_pkg::verdict_t verdict;
  logic                 out_free;
  logic                 step;
  logic                 in_ready;

  // Handshake control
  assign out_free = !out_valid_q || verdict_o.ready;
  assign step     = in_valid_q && (!in_final_q || out_free);
  assign in_ready = !in_valid_q || step;
  assign char_i.ready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && char_i.valid) begin
      in_byte_q  <= char_i.char_byte;
      in_final_q <= char_i.is_final;
    end
  end

  fen_rv_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_byte_i (in_byte_q),
    .is_final_i  (in_final_q),
    .verdict_o   (verdict)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) out_valid_d = step && in_final_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_final_q) begin
      out_q <= verdict;
    end
  end

  assign verdict_o.valid      = out_valid_q;
  assign verdict_o.is_valid   = out_q.is_valid;
  assign verdict_o.error_code = out_q.error_code;

  // Checks
  a_valid_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.is_valid == (out_q.error_code == fen_rv_pkg::ErrNone)))
    else $error("is_valid disagrees with error_code");

  a_code_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.error_code <= fen_rv_pkg::ErrRankSum))
    else $error("error_code out of range");

  a_stall_only_on_blocked_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (in_valid_q && in_final_q && out_valid_q && !verdict_o.ready))
    else $error("input stalled without a blocked verdict");

  a_verdict_follows_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_final_q) |=> out_valid_q)
    else $error("final byte stepped but no verdict registered");

endmodule

@@ hw/rtl/fen_rv_classify.sv @@
// -----------------------------------------------------------------------------
// fen_rv_classify
// Decodes one byte into the symbol classes used by the token checks.
// -----------------------------------------------------------------------------
module fen_rv_classify (
  input  logic [7:0]              char_byte_i,
  output fen_rv_pkg::char_class_t class_o
);

  logic piece;

  // Piece letters
  always_comb begin
    unique case (char_byte_i)
      "r", "n", "b", "q", "k", "p",
      "R", "N", "B", "Q", "K", "P": piece = 1'b1;
      default:                      piece = 1'b0;
    endcase
  end

  // Class flags
  always_comb begin
    class_o.space     = (char_byte_i == 8'd32) ||
                        (char_byte_i >= 8'd9 && char_byte_i <= 8'd13);
    class_o.digit     = (char_byte_i >= "0" && char_byte_i <= "9");
    class_o.nz_digit  = (char_byte_i >= "1" && char_byte_i <= "9");
    class_o.board_sym = piece || (char_byte_i >= "1" && char_byte_i <= "8");
    class_o.slash     = (char_byte_i == "/");
    class_o.side_sym  = (char_byte_i == "w") || (char_byte_i == "b");
    class_o.castle    = (char_byte_i == "K") || (char_byte_i == "Q") ||
                        (char_byte_i == "k") || (char_byte_i == "q");
    class_o.dash      = (char_byte_i == "-");
    class_o.file      = (char_byte_i >= "a" && char_byte_i <= "h");
    class_o.ep_rank   = (char_byte_i == "3") || (char_byte_i == "6");
    // a digit counts its value, a letter one square
    class_o.squares   = piece ? 4'd1 : char_byte_i[3:0];
  end

endmodule

@@ hw/rtl/fen_rv_tracker.sv @@
// -----------------------------------------------------------------------------
// fen_rv_tracker
// Running token state of one record; folds in one byte per step and forms
// the verdict on the final byte.
// -----------------------------------------------------------------------------
module fen_rv_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           char_byte_i,
  input  logic                 is_final_i,
  output fen_rv_pkg::verdict_t verdict_o
);

  fen_rv_pkg::char_class_t cls;

  logic [2:0] tok_idx_q,   tok_idx_d;
  logic       inside_q,    inside_d;
  logic [2:0] tok_len_q,   tok_len_d;
  logic [3:0] rank_cnt_q,  rank_cnt_d;
  logic [3:0] rank_chr_q,  rank_chr_d;
  logic [6:0] rank_sq_q,   rank_sq_d;
  logic [5:0] field_bad_q, field_bad_d;
  logic       sum_bad_q,   sum_bad_d;
  logic [1:0] first_q,     first_d;

  logic [2:0] tok;
  logic       do_close;
  logic [7:0] sq_sum;
  logic [3:0] code;

  fen_rv_classify u_classify (
    .char_byte_i (char_byte_i),
    .class_o     (cls)
  );

  // Byte step: take the byte, then close the token where it ends
  always_comb begin
    tok_idx_d   = tok_idx_q;
    inside_d    = inside_q;
    tok_len_d   = tok_len_q;
    rank_cnt_d  = rank_cnt_q;
    rank_chr_d  = rank_chr_q;
    rank_sq_d   = rank_sq_q;
    field_bad_d = field_bad_q;
    sum_bad_d   = sum_bad_q;
    first_d     = first_q;
    sq_sum      = '0;

    if (!cls.space) begin
      // new token starts
      if (!inside_q) begin
        if (tok_idx_q != 3'd7) tok_idx_d = tok_idx_q + 3'd1;
        tok_len_d = '0;
        first_d   = fen_rv_pkg::FirstOther;
      end
      inside_d = 1'b1;
    end else begin
      inside_d = 1'b0;
    end
    tok = tok_idx_d - 3'd1;

    // Pattern checks on the byte
    if (!cls.space) begin
      unique case (tok)
        fen_rv_pkg::TokBoard: begin
          if (cls.slash) begin
            if (rank_chr_d == 4'd0 || rank_chr_d > 4'd8) field_bad_d[0] = 1'b1;
            if (rank_sq_d != 7'(fen_rv_pkg::RankSquares)) sum_bad_d = 1'b1;
            rank_chr_d = '0;
            rank_sq_d  = '0;
            if (rank_cnt_d >= 4'(fen_rv_pkg::LastRank)) field_bad_d[0] = 1'b1;
            if (rank_cnt_d != 4'd15) rank_cnt_d = rank_cnt_d + 4'd1;
          end else if (cls.board_sym) begin
            sq_sum    = {1'b0, rank_sq_d} + {4'd0, cls.squares};
            rank_sq_d = sq_sum[7] ? 7'd127 : sq_sum[6:0];
            if (rank_chr_d < 4'd9) rank_chr_d = rank_chr_d + 4'd1;
          end else begin
            field_bad_d[0] = 1'b1;
          end
        end
        fen_rv_pkg::TokSide: begin
          if (!cls.side_sym) field_bad_d[1] = 1'b1;
        end
        fen_rv_pkg::TokCastling: begin
          if (tok_len_d == 3'd0) begin
            if (cls.dash) first_d = fen_rv_pkg::FirstDash;
            else if (cls.castle) first_d = fen_rv_pkg::FirstLetter;
            else begin
              first_d        = fen_rv_pkg::FirstOther;
              field_bad_d[2] = 1'b1;
            end
          end else if (first_d != fen_rv_pkg::FirstLetter || !cls.castle) begin
            field_bad_d[2] = 1'b1;
          end
        end
        fen_rv_pkg::TokEnPassant: begin
          if (tok_len_d == 3'd0) begin
            if (cls.dash) first_d = fen_rv_pkg::FirstDash;
            else if (cls.file) first_d = fen_rv_pkg::FirstLetter;
            else begin
              first_d        = fen_rv_pkg::FirstOther;
              field_bad_d[3] = 1'b1;
            end
          end else if (tok_len_d == 3'd1) begin
            if (first_d != fen_rv_pkg::FirstLetter || !cls.ep_rank) field_bad_d[3] = 1'b1;
          end else begin
            field_bad_d[3] = 1'b1;
          end
        end
        fen_rv_pkg::TokHalfmove: begin
          if (!cls.digit) field_bad_d[4] = 1'b1;
        end
        fen_rv_pkg::TokFullmove: begin
          if (tok_len_d == 3'd0) begin
            if (!cls.nz_digit) field_bad_d[5] = 1'b1;
          end else if (!cls.digit) begin
            field_bad_d[5] = 1'b1;
          end
        end
        default: ;
      endcase
      if (tok_len_d != 3'd7) tok_len_d = tok_len_d + 3'd1;
    end

    // Token end: whitespace after a token, or the final byte inside one
    do_close = cls.space ? inside_q : is_final_i;
    if (do_close && tok_idx_d != 3'd0) begin
      unique case (tok)
        fen_rv_pkg::TokBoard: begin
          if (rank_chr_d == 4'd0 || rank_chr_d > 4'd8) field_bad_d[0] = 1'b1;
          if (rank_sq_d != 7'(fen_rv_pkg::RankSquares)) sum_bad_d = 1'b1;
          rank_chr_d = '0;
          rank_sq_d  = '0;
          if (rank_cnt_d != 4'(fen_rv_pkg::LastRank)) field_bad_d[0] = 1'b1;
        end
        fen_rv_pkg::TokSide: begin
          if (tok_len_d != 3'd1) field_bad_d[1] = 1'b1;
        end
        fen_rv_pkg::TokCastling: begin
          if (first_d == fen_rv_pkg::FirstLetter && tok_len_d > 3'd4) field_bad_d[2] = 1'b1;
        end
        fen_rv_pkg::TokEnPassant: begin
          if (first_d == fen_rv_pkg::FirstLetter && tok_len_d != 3'd2) field_bad_d[3] = 1'b1;
        end
        default: ;
      endcase
    end

    // Verdict in check order
    if (tok_idx_d != 3'(fen_rv_pkg::FenTokens)) code = fen_rv_pkg::ErrCount;
    else if (field_bad_d[0]) code = fen_rv_pkg::ErrBoard;
    else if (field_bad_d[1]) code = fen_rv_pkg::ErrSide;
    else if (field_bad_d[2]) code = fen_rv_pkg::ErrCastling;
    else if (field_bad_d[3]) code = fen_rv_pkg::ErrEnPassant;
    else if (field_bad_d[4]) code = fen_rv_pkg::ErrHalfmove;
    else if (field_bad_d[5]) code = fen_rv_pkg::ErrFullmove;
    else if (sum_bad_d) code = fen_rv_pkg::ErrRankSum;
    else code = fen_rv_pkg::ErrNone;

    // A verdict ends the record
    if (is_final_i) begin
      tok_idx_d   = '0;
      inside_d    = 1'b0;
      tok_len_d   = '0;
      rank_cnt_d  = '0;
      rank_chr_d  = '0;
      rank_sq_d   = '0;
      field_bad_d = '0;
      sum_bad_d   = 1'b0;
      first_d     = fen_rv_pkg::FirstOther;
    end
  end

  assign verdict_o.is_valid   = (code == fen_rv_pkg::ErrNone);
  assign verdict_o.error_code = code;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_idx_q   <= '0;
      inside_q    <= 1'b0;
      tok_len_q   <= '0;
      rank_cnt_q  <= '0;
      rank_chr_q  <= '0;
      rank_sq_q   <= '0;
      field_bad_q <= '0;
      sum_bad_q   <= 1'b0;
      first_q     <= fen_rv_pkg::FirstOther;
    end else if (step_i) begin
      tok_idx_q   <= tok_idx_d;
      inside_q    <= inside_d;
      tok_len_q   <= tok_len_d;
      rank_cnt_q  <= rank_cnt_d;
      rank_chr_q  <= rank_chr_d;
      rank_sq_q   <= rank_sq_d;
      field_bad_q <= field_bad_d;
      sum_bad_q   <= sum_bad_d;
      first_q     <= first_d;
    end
  end

endmodule
